[rtl/triangle_pixel_shader_zbuffer_core_defines.svh]
// ----------------------------------------------------------------------------
// triangle pixel shader assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PIXEL_SHADER_ZBUFFER_CORE_DEFINES_SVH
`define TRIANGLE_PIXEL_SHADER_ZBUFFER_CORE_DEFINES_SVH

// same-cycle implication
`define TPSZ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPSZ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tpsz_pkg.sv]
// ----------------------------------------------------------------------------
// tpsz_pkg
// types and constants of the triangle pixel shader
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpsz_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_COMMIT = 2'd1,
    OP_SHADE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vertex_red;
    logic signed [15:0] vertex_green;
    logic signed [15:0] vertex_blue;
    logic signed [31:0] depth_value;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic        written;
    logic [12:0] out_red;
    logic [12:0] out_green;
    logic [12:0] out_blue;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

  localparam logic signed [31:0] DEPTH_MIN = 32'sh8000_0000;
  localparam int unsigned DET_W   = 51;
  localparam int unsigned NORM_W  = 24;
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned MSB_W   = 6;
  localparam logic [MSB_W-1:0] NORM_MSB = 6'd23;
  localparam logic [12:0] COL_MAX = 13'd4096;

endpackage

[rtl/tpsz_depth_mem.sv]
// ----------------------------------------------------------------------------
// tpsz_depth_mem
// single-port depth store with registered read and a clear sweep after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsz_depth_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tpsz_pkg::mem_ctrl_t     ctrl_i,
  input  logic [AW-1:0]           addr_i,
  input  logic signed [31:0]      wdata_i,
  output logic signed [31:0]      rdata_o,
  output logic                    sweep_busy_o
);

  logic signed [31:0] mem [DEPTH];
  logic [AW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic          sweep_q, sweep_d;
  logic          we;
  logic [AW-1:0] waddr;
  logic signed [31:0] wdata;

  always_comb begin
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    if (sweep_q) begin
      sweep_cnt_d = sweep_cnt_q + 1'b1;
      if (sweep_cnt_q == AW'(DEPTH - 1)) begin
        sweep_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
    end else begin
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  assign we    = sweep_q | ctrl_i.wr_en;
  assign waddr = sweep_q ? sweep_cnt_q : addr_i;
  assign wdata = sweep_q ? tpsz_pkg::DEPTH_MIN : wdata_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_o <= mem[addr_i];
    end
  end

  assign sweep_busy_o = sweep_q;

endmodule

[rtl/tpsz_recip.sv]
// ----------------------------------------------------------------------------
// tpsz_recip
// normalizes the determinant magnitude and divides 2^47 by it, one bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsz_recip (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tpsz_pkg::DET_W-1:0]          mag_i,
  output logic                                done_o,
  output logic [tpsz_pkg::RECIP_W-1:0]        recip_o,
  output logic [tpsz_pkg::MSB_W-1:0]          msb_o
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_NORM = 2'd1;
  localparam logic [1:0] R_DIV  = 2'd2;

  logic [1:0]                         phase_q, phase_d;
  logic [tpsz_pkg::DET_W-1:0]         m_q, m_d;
  logic [tpsz_pkg::MSB_W-1:0]         msb_q, msb_d;
  logic [tpsz_pkg::RECIP_W-1:0]       rem_q, rem_d;
  logic [tpsz_pkg::RECIP_W-1:0]       quo_q, quo_d;
  logic [4:0]                         cnt_q, cnt_d;
  logic                               done_q, done_d;
  logic [tpsz_pkg::RECIP_W-1:0]       divisor;
  logic [tpsz_pkg::RECIP_W-1:0]       rem_sel;
  logic                               fits;

  assign divisor = {1'b0, m_q[tpsz_pkg::NORM_W-1:0]};
  assign fits    = rem_q >= divisor;
  assign rem_sel = fits ? (rem_q - divisor) : rem_q;

  always_comb begin
    phase_d = phase_q;
    m_d     = m_q;
    msb_d   = msb_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (phase_q)
      R_IDLE: begin
        if (start_i) begin
          m_d     = mag_i;
          msb_d   = tpsz_pkg::NORM_MSB;
          phase_d = R_NORM;
        end
      end
      R_NORM: begin
        // bring the magnitude into [2^23, 2^24)
        if (m_q[tpsz_pkg::DET_W-1:tpsz_pkg::NORM_W] != '0) begin
          m_d   = m_q >> 1;
          msb_d = msb_q + 1'b1;
        end else if (!m_q[tpsz_pkg::NORM_W-1]) begin
          m_d   = m_q << 1;
          msb_d = msb_q - 1'b1;
        end else begin
          rem_d   = tpsz_pkg::RECIP_W'(1) << (tpsz_pkg::NORM_W - 1);
          quo_d   = '0;
          cnt_d   = '0;
          phase_d = R_DIV;
        end
      end
      R_DIV: begin
        quo_d = {quo_q[tpsz_pkg::RECIP_W-2:0], fits};
        rem_d = rem_sel << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(tpsz_pkg::RECIP_W - 1)) begin
          done_d  = 1'b1;
          phase_d = R_IDLE;
        end
      end
      default: begin
        phase_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= R_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    msb_q <= msb_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o  = done_q;
  assign recip_o = quo_q;
  assign msb_o   = msb_q;

endmodule

[rtl/triangle_pixel_shader_zbuffer_core.sv]
// ----------------------------------------------------------------------------
// triangle_pixel_shader_zbuffer_core
// gouraud triangle pixel shader with barycentric coverage and depth store
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                      payload
// command   in         start_i & !busy_o              cmd_i    (tpsz_pkg::cmd_t)
// result    out        done_o, one cycle, no stall    result_o (tpsz_pkg::result_t)
// config    in         cfg_we_i, always taken         cfg_wdata_i (depth test enable)
//
// load and clear complete on acceptance, busy_o stays low; shade runs multiply, sum, test,
// the depth test if enabled (depth store read, then write), normalize, weight, colour, sum;
// the result strobes in the first cycle with busy_o low; rejected pixels finish early
// commit runs the determinant multiply, sum and check, then the reciprocal unit; a zero
// determinant ends after the check; after reset the depth store is swept, busy_o high until it ends
// results cannot be stalled; the next transaction is taken on the strobe cycle
//
`timescale 1ns / 1ps

module triangle_pixel_shader_zbuffer_core #(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  tpsz_pkg::cmd_t      cmd_i,
  output logic                done_o,
  output tpsz_pkg::result_t   result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  localparam int unsigned NUM_PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned IDX_W   = (NUM_PIX > 1) ? $clog2(NUM_PIX) : 1;
  localparam int unsigned N_W     = 53;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned CP_W    = 34;
  localparam int unsigned ACC_W   = 36;

  // sequencer codes
  localparam logic [3:0] ST_SWEEP    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DET_MUL  = 4'd2;
  localparam logic [3:0] ST_DET_SUM  = 4'd3;
  localparam logic [3:0] ST_DET_CHK  = 4'd4;
  localparam logic [3:0] ST_DET_RCP  = 4'd5;
  localparam logic [3:0] ST_SH_MUL   = 4'd6;
  localparam logic [3:0] ST_SH_SUM   = 4'd7;
  localparam logic [3:0] ST_SH_TEST  = 4'd8;
  localparam logic [3:0] ST_SH_DEPTH = 4'd9;
  localparam logic [3:0] ST_SH_NORM  = 4'd10;
  localparam logic [3:0] ST_SH_WGT   = 4'd11;
  localparam logic [3:0] ST_SH_COL   = 4'd12;
  localparam logic [3:0] ST_SH_ACC   = 4'd13;

  logic [3:0] state_q, state_d;

  // triangle setup state
  logic signed [23:0] vx_q [3];
  logic signed [23:0] vy_q [3];
  logic signed [15:0] col_q [3][3];
  logic signed [31:0] tri_depth_q;
  logic [tpsz_pkg::RECIP_W-1:0] recip_q;
  logic [tpsz_pkg::MSB_W-1:0]   msb_q;
  logic                         valid_q;
  logic signed [tpsz_pkg::DET_W-1:0] det_q;
  logic                         dte_q;

  // shade datapath registers
  logic [7:0]                   px_q, py_q;
  logic [IDX_W-1:0]             idx_q;
  logic                         onscr_q;
  logic signed [49:0]           prod_q [4];
  logic signed [N_W-1:0]        n_q [3];
  logic [tpsz_pkg::DET_W-1:0]   mag_q [3];
  logic [tpsz_pkg::NORM_W-1:0]  sh_q [3];
  logic [WGT_W-1:0]             w_q [3];
  logic signed [CP_W-1:0]       cp_q [3][3];
  tpsz_pkg::result_t            result_q, result_d;
  logic                         done_q, done_d;

  // command decode
  logic [1:0]        vsel;
  logic [31:0]       lin_idx;
  logic              cmd_onscr;
  logic              accept;

  // recip unit
  logic                         rcp_start;
  logic [tpsz_pkg::DET_W-1:0]   rcp_mag;
  logic                         rcp_done;
  logic [tpsz_pkg::RECIP_W-1:0] rcp_val;
  logic [tpsz_pkg::MSB_W-1:0]   rcp_msb;

  // depth store
  tpsz_pkg::mem_ctrl_t mem_ctrl;
  logic [IDX_W-1:0]    mem_addr;
  logic signed [31:0]  mem_wdata;
  logic signed [31:0]  mem_rdata;
  logic                sweep_busy;

  // combinational datapath
  logic signed [24:0] dx, dy;
  logic signed [24:0] ca0, cb0, ca1, cb1;
  logic signed [24:0] ex0, ey0;
  logic signed [N_W-1:0] nsum0, nsum1, nsum2;
  logic               det_neg;
  logic [2:0]         neg_k;
  logic               covered;
  logic signed [tpsz_pkg::DET_W-1:0] det_sum;
  logic [tpsz_pkg::NORM_W-1:0] sh_d [3];
  logic [48:0]        wprod [3];
  logic signed [ACC_W-1:0] acc [3];
  logic [12:0]        col_out [3];

  // shift a covered numerator like the determinant magnitude
  function automatic logic [tpsz_pkg::NORM_W-1:0] norm_shift(
    input logic [tpsz_pkg::DET_W-1:0] u,
    input logic [tpsz_pkg::MSB_W-1:0] msb
  );
    logic [tpsz_pkg::DET_W-1:0] t;
    if (msb >= tpsz_pkg::NORM_MSB) begin
      t = u >> (msb - tpsz_pkg::NORM_MSB);
    end else begin
      t = u << (tpsz_pkg::NORM_MSB - msb);
    end
    return t[tpsz_pkg::NORM_W-1:0];
  endfunction

  assign accept    = start_i & ~busy_o;
  assign vsel      = (cmd_i.vertex_index > 2'd2) ? 2'd2 : cmd_i.vertex_index;
  assign lin_idx   = 32'(cmd_i.pixel_y) * 32'(SCREEN_WIDTH) + 32'(cmd_i.pixel_x);
  assign cmd_onscr = (32'(cmd_i.pixel_x) < 32'(SCREEN_WIDTH)) &&
                     (32'(cmd_i.pixel_y) < 32'(SCREEN_HEIGHT));

  // edge terms against vertex 2
  assign dx  = $signed({9'd0, px_q, 8'd0}) - 25'(vx_q[2]);
  assign dy  = $signed({9'd0, py_q, 8'd0}) - 25'(vy_q[2]);
  assign ca0 = 25'(vy_q[1]) - 25'(vy_q[2]);
  assign cb0 = 25'(vx_q[2]) - 25'(vx_q[1]);
  assign ca1 = 25'(vy_q[2]) - 25'(vy_q[0]);
  assign cb1 = 25'(vx_q[0]) - 25'(vx_q[2]);
  assign ex0 = 25'(vx_q[0]) - 25'(vx_q[2]);
  assign ey0 = 25'(vy_q[0]) - 25'(vy_q[2]);

  assign nsum0   = N_W'(prod_q[0]) + N_W'(prod_q[1]);
  assign nsum1   = N_W'(prod_q[2]) + N_W'(prod_q[3]);
  assign nsum2   = N_W'(det_q) - nsum0 - nsum1;
  assign det_sum = tpsz_pkg::DET_W'(prod_q[0]) + tpsz_pkg::DET_W'(prod_q[1]);
  assign det_neg = det_q[tpsz_pkg::DET_W-1];

  // coverage after folding the determinant sign into the numerators
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_k[k] = det_neg ? ((n_q[k] != '0) && !n_q[k][N_W-1]) : n_q[k][N_W-1];
    end
  end
  assign covered = (neg_k == 3'b000);

  assign rcp_mag = det_neg ? tpsz_pkg::DET_W'(-det_q) : tpsz_pkg::DET_W'(det_q);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh_d[k]  = norm_shift(mag_q[k], msb_q);
      wprod[k] = 49'(sh_q[k]) * 49'(recip_q);
    end
  end

  // per channel sum and clamp to 0..1
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = ACC_W'(cp_q[0][ch]) + ACC_W'(cp_q[1][ch]) + ACC_W'(cp_q[2][ch]);
      if (acc[ch] <= 0) begin
        col_out[ch] = '0;
      end else if (acc[ch][ACC_W-1:16] > 20'(tpsz_pkg::COL_MAX)) begin
        col_out[ch] = tpsz_pkg::COL_MAX;
      end else begin
        col_out[ch] = acc[ch][28:16];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    result_d  = result_q;
    mem_ctrl  = '0;
    mem_addr  = idx_q;
    mem_wdata = tri_depth_q;
    rcp_start = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        if (!sweep_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = lin_idx[IDX_W-1:0];
        if (accept) begin
          case (cmd_i.op)
            tpsz_pkg::OP_COMMIT: state_d = ST_DET_MUL;
            tpsz_pkg::OP_SHADE:  state_d = ST_SH_MUL;
            tpsz_pkg::OP_CLEAR: begin
              mem_ctrl.wr_en = cmd_onscr;
              mem_wdata      = tpsz_pkg::DEPTH_MIN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DET_MUL: state_d = ST_DET_SUM;
      ST_DET_SUM: state_d = ST_DET_CHK;
      ST_DET_CHK: begin
        if (det_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          rcp_start = 1'b1;
          state_d   = ST_DET_RCP;
        end
      end
      ST_DET_RCP: begin
        if (rcp_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SH_MUL: state_d = ST_SH_SUM;
      ST_SH_SUM: state_d = ST_SH_TEST;
      ST_SH_TEST: begin
        result_d = '{out_x: px_q, out_y: py_q, written: 1'b0,
                     out_red: '0, out_green: '0, out_blue: '0};
        if (!valid_q || !onscr_q || !covered) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (dte_q) begin
          mem_ctrl.rd_en = 1'b1;
          state_d        = ST_SH_DEPTH;
        end else begin
          state_d = ST_SH_NORM;
        end
      end
      ST_SH_DEPTH: begin
        // strictly nearer wins and is stored
        if (tri_depth_q > mem_rdata) begin
          mem_ctrl.wr_en = 1'b1;
          state_d        = ST_SH_NORM;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SH_NORM: state_d = ST_SH_WGT;
      ST_SH_WGT:  state_d = ST_SH_COL;
      ST_SH_COL:  state_d = ST_SH_ACC;
      ST_SH_ACC: begin
        result_d.written   = 1'b1;
        result_d.out_red   = col_out[0];
        result_d.out_green = col_out[1];
        result_d.out_blue  = col_out[2];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      done_q      <= 1'b0;
      dte_q       <= 1'b0;
      valid_q     <= 1'b0;
      recip_q     <= '0;
      msb_q       <= '0;
      det_q       <= '0;
      tri_depth_q <= tpsz_pkg::DEPTH_MIN;
      for (int v = 0; v < 3; v++) begin
        vx_q[v] <= '0;
        vy_q[v] <= '0;
        for (int ch = 0; ch < 3; ch++) begin
          col_q[v][ch] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        dte_q <= cfg_wdata_i;
      end
      if (accept && (cmd_i.op == tpsz_pkg::OP_LOAD)) begin
        vx_q[vsel]     <= cmd_i.pos_x;
        vy_q[vsel]     <= cmd_i.pos_y;
        col_q[vsel][0] <= cmd_i.vertex_red;
        col_q[vsel][1] <= cmd_i.vertex_green;
        col_q[vsel][2] <= cmd_i.vertex_blue;
      end
      if (accept && (cmd_i.op == tpsz_pkg::OP_COMMIT)) begin
        tri_depth_q <= cmd_i.depth_value;
      end
      if (state_q == ST_DET_SUM) begin
        det_q <= det_sum;
      end
      if ((state_q == ST_DET_CHK) && (det_q == '0)) begin
        valid_q <= 1'b0;
        recip_q <= '0;
        msb_q   <= '0;
      end
      if ((state_q == ST_DET_RCP) && rcp_done) begin
        valid_q <= 1'b1;
        recip_q <= rcp_val;
        msb_q   <= rcp_msb;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (accept) begin
      px_q    <= cmd_i.pixel_x;
      py_q    <= cmd_i.pixel_y;
      idx_q   <= lin_idx[IDX_W-1:0];
      onscr_q <= cmd_onscr;
    end
    if (state_q == ST_DET_MUL) begin
      prod_q[0] <= ca0 * ex0;
      prod_q[1] <= cb0 * ey0;
    end
    if (state_q == ST_SH_MUL) begin
      prod_q[0] <= ca0 * dx;
      prod_q[1] <= cb0 * dy;
      prod_q[2] <= ca1 * dx;
      prod_q[3] <= cb1 * dy;
    end
    if (state_q == ST_SH_SUM) begin
      n_q[0] <= nsum0;
      n_q[1] <= nsum1;
      n_q[2] <= nsum2;
    end
    if (state_q == ST_SH_TEST) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= det_neg ? tpsz_pkg::DET_W'(-n_q[k]) : tpsz_pkg::DET_W'(n_q[k]);
      end
    end
    if (state_q == ST_SH_NORM) begin
      for (int k = 0; k < 3; k++) begin
        sh_q[k] <= sh_d[k];
      end
    end
    if (state_q == ST_SH_WGT) begin
      for (int k = 0; k < 3; k++) begin
        w_q[k] <= wprod[k][47:31];
      end
    end
    if (state_q == ST_SH_COL) begin
      for (int k = 0; k < 3; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          cp_q[k][ch] <= $signed({1'b0, w_q[k]}) * col_q[k][ch];
        end
      end
    end
  end

  tpsz_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rcp_start),
    .mag_i   (rcp_mag),
    .done_o  (rcp_done),
    .recip_o (rcp_val),
    .msb_o   (rcp_msb)
  );

  tpsz_depth_mem #(
    .DEPTH (NUM_PIX),
    .AW    (IDX_W)
  ) u_depth_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mem_ctrl),
    .addr_i       (mem_addr),
    .wdata_i      (mem_wdata),
    .rdata_o      (mem_rdata),
    .sweep_busy_o (sweep_busy)
  );

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[rtl/tpsz_checker.sv]
// ----------------------------------------------------------------------------
// tpsz_checker
// port-level checks of the triangle pixel shader, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_pixel_shader_zbuffer_core_defines.svh"

module tpsz_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input tpsz_pkg::cmd_t    cmd_i,
  input logic              done_o,
  input tpsz_pkg::result_t result_o
);

  `TPSZ_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "result strobe while busy")
  `TPSZ_ASSERT_NXT(a_no_result, clk_i, rst_ni, start_i && !busy_o && (cmd_i.op != tpsz_pkg::OP_SHADE), !done_o, "result after non-shade transaction")
  `TPSZ_ASSERT_NXT(a_shade_busy, clk_i, rst_ni, start_i && !busy_o && (cmd_i.op == tpsz_pkg::OP_SHADE), busy_o, "shade transaction did not go busy")
  `TPSZ_ASSERT_IMP(a_reject_black, clk_i, rst_ni, done_o && !result_o.written, (result_o.out_red == '0) && (result_o.out_green == '0) && (result_o.out_blue == '0), "rejected pixel with colour")
  `TPSZ_ASSERT_IMP(a_col_range, clk_i, rst_ni, done_o, (result_o.out_red <= tpsz_pkg::COL_MAX) && (result_o.out_green <= tpsz_pkg::COL_MAX) && (result_o.out_blue <= tpsz_pkg::COL_MAX), "colour above one")

endmodule

bind triangle_pixel_shader_zbuffer_core tpsz_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);
